>>> hdl/lbe_pkg.sv
// Shared types and constants for the eight-string LED bit-plane encoder.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package lbe_pkg;

    localparam int NUM_CH      = 8;
    localparam int LEN_W       = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int WORD_NUM_W  = 3;

    typedef logic [7:0]              pixel_idx_t;
    typedef logic [23:0]             color_t;
    typedef logic [LEN_W-1:0]        length_t;
    typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
    typedef logic [31:0]             plane_word_t;
    typedef logic [WORD_NUM_W-1:0]   word_num_t;

    // Word numbers 0..5 run G high, G low, R high, R low, B high, B low.
    localparam word_num_t FIRST_WORD_NUM = 3'd0;
    localparam word_num_t LAST_WORD_NUM  = 3'd5;

endpackage

`default_nettype wire

>>> hdl/lbe_pixel_if.sv
// Valid/ready channel interfaces for pixel input and plane-word output.
// Depends on lbe_pkg for the payload types.
`default_nettype none

interface lbe_pixel_if;
    import lbe_pkg::*;

    logic       valid;
    logic       ready;
    pixel_idx_t pixel_index;
    color_t     color_ch0;
    color_t     color_ch1;
    color_t     color_ch2;
    color_t     color_ch3;
    color_t     color_ch4;
    color_t     color_ch5;
    color_t     color_ch6;
    color_t     color_ch7;

    modport source
    (
        output valid, pixel_index,
        output color_ch0, color_ch1, color_ch2, color_ch3,
        output color_ch4, color_ch5, color_ch6, color_ch7,
        input  ready
    );

    modport sink
    (
        input  valid, pixel_index,
        input  color_ch0, color_ch1, color_ch2, color_ch3,
        input  color_ch4, color_ch5, color_ch6, color_ch7,
        output ready
    );
endinterface

interface lbe_word_if;
    import lbe_pkg::*;

    logic        valid;
    logic        ready;
    plane_word_t plane_word;
    word_num_t   word_number;
    logic        last_word;

    modport source
    (
        output valid, plane_word, word_number, last_word,
        input  ready
    );

    modport sink
    (
        input  valid, plane_word, word_number, last_word,
        output ready
    );
endinterface

`default_nettype wire

>>> hdl/led_bitplane_encoder_8ch.sv
// A taken pixel is held in color_reg; its first plane word then loads into plane_reg.
// Each pixel gives six 32-bit words; the output channel moves one word per cycle while
// ready is high, and the next pixel is taken as the previous one's last word loads.
// Pixels whose index is at or beyond MAX_PIXELS are taken and dropped with no output.
// Reset clears all string lengths to zero and empties the holding and output registers.
// Top level of the encoder; depends on lbe_pkg and the interfaces in lbe_pixel_if.sv.
`default_nettype none

module led_bitplane_encoder_8ch #(
    parameter int MAX_PIXELS = 128
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire lbe_pkg::cfg_idx_t cfg_index,
    input  wire lbe_pkg::length_t  cfg_data,
    lbe_pixel_if.sink             pixel_in,
    lbe_word_if.source            word_out
);
    import lbe_pkg::*;

    localparam pixel_idx_t MaxPix = pixel_idx_t'(MAX_PIXELS);

    length_t     length_reg [NUM_CH];

    logic        hold_valid_reg;
    word_num_t   word_cnt_reg;
    color_t      color_reg  [NUM_CH];
    color_t      color_next [NUM_CH];
    color_t      color_in   [NUM_CH];

    logic        out_valid_reg;
    plane_word_t plane_reg;
    plane_word_t plane_next;
    word_num_t   word_num_reg;
    logic        last_reg;

    logic        out_load;
    logic        hold_free;
    logic        in_accept;
    logic        in_keep;

    logic [7:0]  sel_byte [NUM_CH];
    logic [3:0]  sel_nib;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < NUM_CH; n++)
            begin
                length_reg[n] <= '0;
            end
        end
        else if (cfg_we)
        begin
            length_reg[cfg_index] <= cfg_data;
        end
    end

    assign color_in[0] = pixel_in.color_ch0;
    assign color_in[1] = pixel_in.color_ch1;
    assign color_in[2] = pixel_in.color_ch2;
    assign color_in[3] = pixel_in.color_ch3;
    assign color_in[4] = pixel_in.color_ch4;
    assign color_in[5] = pixel_in.color_ch5;
    assign color_in[6] = pixel_in.color_ch6;
    assign color_in[7] = pixel_in.color_ch7;

    // Strings whose length is not above the pixel index are blanked as the word is taken.
    always_comb
    begin
        for (int n = 0; n < NUM_CH; n++)
        begin
            color_next[n] = (pixel_in.pixel_index < length_reg[n]) ? color_in[n] : '0;
        end
    end

    assign out_load  = !out_valid_reg || word_out.ready;
    assign hold_free = out_load && hold_valid_reg && (word_cnt_reg == LAST_WORD_NUM);
    assign pixel_in.ready = !hold_valid_reg || hold_free;
    assign in_accept = pixel_in.valid && pixel_in.ready;
    assign in_keep   = in_accept && (pixel_in.pixel_index < MaxPix);

    // Transpose: byte b of the word holds the inverted color bit (7 - 4*half - b) of every string.
    always_comb
    begin
        sel_nib = '0;
        for (int n = 0; n < NUM_CH; n++)
        begin
            case (word_cnt_reg[2:1])
                2'd0:    sel_byte[n] = color_reg[n][23:16];
                2'd1:    sel_byte[n] = color_reg[n][15:8];
                default: sel_byte[n] = color_reg[n][7:0];
            endcase
        end
        for (int n = 0; n < NUM_CH; n++)
        begin
            sel_nib = word_cnt_reg[0] ? sel_byte[n][3:0] : sel_byte[n][7:4];
            for (int b = 0; b < 4; b++)
            begin
                plane_next[8*b + n] = ~sel_nib[3 - b];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            word_cnt_reg   <= FIRST_WORD_NUM;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_keep)
            begin
                hold_valid_reg <= 1'b1;
                word_cnt_reg   <= FIRST_WORD_NUM;
            end
            else if (hold_free)
            begin
                hold_valid_reg <= 1'b0;
            end
            else if (out_load && hold_valid_reg)
            begin
                word_cnt_reg <= word_cnt_reg + 3'd1;
            end

            if (out_load)
            begin
                out_valid_reg <= hold_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_keep)
        begin
            for (int n = 0; n < NUM_CH; n++)
            begin
                color_reg[n] <= color_next[n];
            end
        end
        if (out_load && hold_valid_reg)
        begin
            plane_reg    <= plane_next;
            word_num_reg <= word_cnt_reg;
            last_reg     <= (word_cnt_reg == LAST_WORD_NUM);
        end
    end

    assign word_out.valid       = out_valid_reg;
    assign word_out.plane_word  = plane_reg;
    assign word_out.word_number = word_num_reg;
    assign word_out.last_word   = last_reg;

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        word_cnt_reg <= LAST_WORD_NUM)
        else $error("word counter out of range");

    a_accept_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> (!hold_valid_reg || (word_cnt_reg == LAST_WORD_NUM && out_load)))
        else $error("pixel taken while the previous pixel still has words pending");

    a_keep_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_keep |=> (hold_valid_reg && word_cnt_reg == FIRST_WORD_NUM))
        else $error("kept pixel did not start at the first word");

    a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && hold_valid_reg) |=> (out_valid_reg
            && word_num_reg == $past(word_cnt_reg)))
        else $error("plane word not presented after load");

    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !in_keep && !hold_valid_reg) |=> !hold_valid_reg)
        else $error("out-of-frame pixel produced words");
`endif

endmodule

`default_nettype wire
